[sv/pfat_pkg.sv]
// ----------------------------------------------------------------------------
// Paged frame allocator package
// Command and status codes and the fixed field widths shared by the design.
// ----------------------------------------------------------------------------
package pfat_pkg;

	localparam int CMD_W = 2;
	localparam int PID_W = 4;
	localparam int STATUS_W = 2;
	localparam int BYTE_W = 8;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd3;

endpackage

[sv/pfat_if.sv]
// ----------------------------------------------------------------------------
// Paged frame allocator channels
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfat_cmd_if
	import pfat_pkg::*;
	#(parameter int VA_BITS = 20) ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [PID_W-1:0]    pid;
	logic [VA_BITS:0]    size_bytes;
	logic [VA_BITS-1:0]  vaddr;
	logic [BYTE_W-1:0]   write_byte;
	modport source(output valid, command, pid, size_bytes, vaddr, write_byte, input ready);
	modport sink(input valid, command, pid, size_bytes, vaddr, write_byte, output ready);
endinterface

interface pfat_rsp_if
	import pfat_pkg::*;
	#(parameter int VA_BITS = 20) ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VA_BITS-1:0]  alloc_address;
	logic [BYTE_W-1:0]   read_byte;
	modport source(output valid, status, alloc_address, read_byte, input ready);
	modport sink(input valid, status, alloc_address, read_byte, output ready);
endinterface

[sv/pfat_ram.sv]
// ----------------------------------------------------------------------------
// Paged frame allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfat_ram #(
	parameter int AW = 4,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/pfat_core.sv]
// ----------------------------------------------------------------------------
// Paged frame allocator core
// Sequencer over the frame owner, frame link, page map and byte memories.
// ----------------------------------------------------------------------------
module pfat_core
	import pfat_pkg::*;
	#(
	parameter int OFFSET_BITS   = 10,
	parameter int PAGE_BITS     = 5,
	parameter int SEGMENT_BITS  = 5,
	parameter int NUM_FRAMES    = 1024,
	parameter int NUM_PROCESSES = 8,
	parameter int INITIAL_BREAK = 1024
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [CMD_W-1:0]                         command,
	input  logic [PID_W-1:0]                         pid,
	input  logic [SEGMENT_BITS+PAGE_BITS+OFFSET_BITS:0]   size_bytes,
	input  logic [SEGMENT_BITS+PAGE_BITS+OFFSET_BITS-1:0] vaddr,
	input  logic [BYTE_W-1:0]                        write_byte,
	input  logic                                     hold,
	output logic                                     idle,
	output logic                                     done,
	output logic [STATUS_W-1:0]                      status,
	output logic [SEGMENT_BITS+PAGE_BITS+OFFSET_BITS-1:0] alloc_address,
	output logic [BYTE_W-1:0]                        read_byte
);

	localparam int O      = OFFSET_BITS;
	localparam int P      = PAGE_BITS;
	localparam int VA     = SEGMENT_BITS + PAGE_BITS + OFFSET_BITS;
	localparam int VPN    = SEGMENT_BITS + PAGE_BITS;
	localparam int FB     = $clog2(NUM_FRAMES);
	localparam int PROC_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int MAW    = PROC_W + VPN;
	localparam int BAW    = FB + O;
	localparam int CW     = (MAW > BAW) ? MAW : BAW;
	localparam int PG_W   = VA + 2 - O;
	localparam int XW     = VA + FB + 3;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MAPRD = 4'd2;
	localparam logic [3:0] S_MAPCK = 4'd3;
	localparam logic [3:0] S_BYTE  = 4'd4;
	localparam logic [3:0] S_APG   = 4'd5;
	localparam logic [3:0] S_ACHK  = 4'd6;
	localparam logic [3:0] S_ARD   = 4'd7;
	localparam logic [3:0] S_ACK   = 4'd8;
	localparam logic [3:0] S_AEND  = 4'd9;
	localparam logic [3:0] S_WRD   = 4'd10;
	localparam logic [3:0] S_WCK   = 4'd11;
	localparam logic [3:0] S_FSPAN = 4'd12;
	localparam logic [3:0] S_UNMAP = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0]          state_q;
	logic [CW-1:0]       clr_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [PID_W-1:0]    pid_q;
	logic [PROC_W-1:0]   pidx_q;
	logic [VA:0]         size_q;
	logic [VA-1:0]       va_q;
	logic [BYTE_W-1:0]   wb_q;
	logic [STATUS_W-1:0] status_q;
	logic [VA-1:0]       addr_q;
	logic [BYTE_W-1:0]   rb_q;
	logic [VA:0]         bp_q [NUM_PROCESSES];
	logic [FB:0]         nfree_q;
	logic [PG_W-1:0]     pages_q;
	logic [PG_W-1:0]     k_q;
	logic [XW-1:0]       span_q;
	logic [VPN-1:0]      vpn_q;
	logic [FB-1:0]       i_q;
	logic [FB-1:0]       prev_q;
	logic                have_prev_q;
	logic [FB-1:0]       fr_q;
	logic [FB:0]         n_q;
	logic [VPN:0]        u_q;
	logic [VPN:0]        lim_q;

	logic          o_we;
	logic [FB-1:0] o_wa;
	logic [PID_W-1:0] o_wd;
	logic [FB-1:0] o_ra;
	logic [PID_W-1:0] o_rd;
	logic          l_we;
	logic [FB-1:0] l_wa;
	logic [FB:0]   l_wd;
	logic [FB:0]   l_rd;
	logic          m_we;
	logic [MAW-1:0] m_wa;
	logic [FB:0]   m_wd;
	logic [FB:0]   m_rd;
	logic          b_we;
	logic [BAW-1:0] b_wa;
	logic [BYTE_W-1:0] b_wd;
	logic [BAW-1:0] b_ra;
	logic [BYTE_W-1:0] b_rd;

	logic [VA:0]   bp;
	logic          pid_ok;
	logic [XW-1:0] pages_x;
	logic [XW-1:0] segs_a;
	logic [XW-1:0] span_a;
	logic [XW-1:0] room_a;
	logic [XW-1:0] n_x;
	logic [XW-1:0] segs_f;
	logic [XW-1:0] span_f;
	logic [XW-1:0] seg_end;

	assign bp     = bp_q[pidx_q];
	assign pid_ok = (pid != '0) && (32'(pid) <= NUM_PROCESSES);

	assign pages_x = XW'(pages_q);
	assign segs_a  = (pages_x >> P) + XW'((pages_x & XW'((1 << P) - 1)) != '0);
	assign span_a  = segs_a << (P + O);
	assign room_a  = (XW'(1) << VA) - XW'(bp);
	assign n_x     = XW'(n_q);
	assign segs_f  = (n_x >> P) + XW'((n_x & XW'((1 << P) - 1)) != '0);
	assign span_f  = segs_f << (P + O);
	assign seg_end = XW'(va_q[VA-1:P+O]) + segs_f;

	assign b_ra = {m_rd[FB-1:0], va_q[O-1:0]};

	always_comb begin
		o_we = 1'b0;
		o_wa = i_q;
		o_wd = pid_q;
		o_ra = (state_q == S_WRD) ? fr_q : i_q;
		l_we = 1'b0;
		l_wa = prev_q;
		l_wd = {1'b0, i_q};
		m_we = 1'b0;
		m_wa = {pidx_q, vpn_q};
		m_wd = {1'b1, i_q};
		b_we = 1'b0;
		b_wa = b_ra;
		b_wd = wb_q;
		unique case (state_q)
			S_CLR: begin
				o_we = 1'b1;
				o_wa = clr_q[FB-1:0];
				o_wd = '0;
				m_we = 1'b1;
				m_wa = clr_q[MAW-1:0];
				m_wd = '0;
				b_we = 1'b1;
				b_wa = clr_q[BAW-1:0];
				b_wd = '0;
			end
			S_MAPCK: begin
				b_we = m_rd[FB] && (cmd_q == CMD_WRITE);
			end
			S_ACK: begin
				o_we = (o_rd == '0);
				l_we = (o_rd == '0) && have_prev_q;
				m_we = (o_rd == '0);
			end
			S_AEND: begin
				l_we = 1'b1;
				l_wd = {1'b1, {FB{1'b0}}};
			end
			S_WCK: begin
				o_we = 1'b1;
				o_wa = fr_q;
				o_wd = '0;
			end
			S_UNMAP: begin
				m_we = 1'b1;
				m_wa = {pidx_q, u_q[VPN-1:0]};
				m_wd = '0;
			end
			default: begin
			end
		endcase
	end

	pfat_ram #(.AW(FB), .DW(PID_W)) u_owner (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
	);
	pfat_ram #(.AW(FB), .DW(FB + 1)) u_link (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(fr_q), .rdata(l_rd)
	);
	pfat_ram #(.AW(MAW), .DW(FB + 1)) u_map (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd),
		.raddr({pidx_q, va_q[VA-1:O]}), .rdata(m_rd)
	);
	pfat_ram #(.AW(BAW), .DW(BYTE_W)) u_bytes (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			nfree_q <= (FB + 1)'(NUM_FRAMES);
			for (int j = 0; j < NUM_PROCESSES; j++) begin
				bp_q[j] <= (VA + 1)'(INITIAL_BREAK);
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						pid_q    <= pid;
						pidx_q   <= PROC_W'(pid - 1'b1);
						size_q   <= size_bytes;
						va_q     <= vaddr;
						wb_q     <= write_byte;
						status_q <= ST_UNMAPPED;
						addr_q   <= '0;
						rb_q     <= '0;
						if (!pid_ok) begin
							state_q <= S_DONE;
						end else if (command == CMD_ALLOC) begin
							state_q <= S_APG;
						end else begin
							state_q <= S_MAPRD;
						end
					end
				end
				S_MAPRD: begin
					state_q <= S_MAPCK;
				end
				S_MAPCK: begin
					fr_q <= m_rd[FB-1:0];
					n_q  <= '0;
					if (!m_rd[FB]) begin
						state_q <= S_DONE;
					end else if (cmd_q == CMD_FREE) begin
						state_q <= S_WRD;
					end else if (cmd_q == CMD_READ) begin
						state_q <= S_BYTE;
					end else begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end
				end
				S_BYTE: begin
					rb_q     <= b_rd;
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_APG: begin
					pages_q <= PG_W'(size_q[VA:O]) + PG_W'(size_q[O-1:0] != '0);
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					span_q      <= span_a;
					vpn_q       <= bp[VA-1:O];
					i_q         <= '0;
					k_q         <= '0;
					have_prev_q <= 1'b0;
					priority if (size_q == '0) begin
						status_q <= ST_NO_SPACE;
						state_q  <= S_DONE;
					end else if (PG_W'(nfree_q) < pages_q) begin
						status_q <= ST_NO_FRAME;
						state_q  <= S_DONE;
					end else if (span_a > room_a) begin
						status_q <= ST_NO_SPACE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					state_q <= S_ACK;
				end
				S_ACK: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_ARD;
					if (o_rd == '0) begin
						prev_q      <= i_q;
						have_prev_q <= 1'b1;
						vpn_q       <= vpn_q + 1'b1;
						k_q         <= k_q + 1'b1;
						if (k_q + 1'b1 == pages_q) begin
							state_q <= S_AEND;
						end
					end
				end
				S_AEND: begin
					nfree_q      <= nfree_q - pages_q[FB:0];
					bp_q[pidx_q] <= bp + span_q[VA:0];
					addr_q       <= bp[VA-1:0];
					status_q     <= ST_OK;
					state_q      <= S_DONE;
				end
				S_WRD: begin
					state_q <= S_WCK;
				end
				S_WCK: begin
					n_q <= n_q + 1'b1;
					if (o_rd != '0) begin
						nfree_q <= nfree_q + 1'b1;
					end
					if (l_rd[FB] || (n_q + 1'b1 == (FB + 1)'(NUM_FRAMES))) begin
						state_q <= S_FSPAN;
					end else begin
						fr_q    <= l_rd[FB-1:0];
						state_q <= S_WRD;
					end
				end
				S_FSPAN: begin
					if (XW'(va_q) + span_f == XW'(bp)) begin
						bp_q[pidx_q] <= bp - span_f[VA:0];
					end
					u_q <= (VPN + 1)'(va_q[VA-1:P+O]) << P;
					if (seg_end >= (XW'(1) << SEGMENT_BITS)) begin
						lim_q <= (VPN + 1)'(1) << VPN;
					end else begin
						lim_q <= (VPN + 1)'(seg_end) << P;
					end
					state_q <= S_UNMAP;
				end
				S_UNMAP: begin
					u_q <= u_q + 1'b1;
					if (u_q + 1'b1 == lim_q) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!hold) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle          = (state_q == S_IDLE);
	assign done          = (state_q == S_DONE) && !hold;
	assign status        = status_q;
	assign alloc_address = addr_q;
	assign read_byte     = rb_q;

endmodule

[sv/paged_frame_allocator_translator.sv]
// ----------------------------------------------------------------------------
// Paged frame allocator and translator
// Allocates, frees and translates paged regions for a set of processes.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel, one beat each, and every command gives
// exactly one beat on the rsp channel.
// A read or a write does a page map read, then a byte memory access; a
// read also registers the byte that it gets.
// An allocate is paced by the scan of the frame owner memory, which checks
// frames in turn from frame 0 until enough free ones are found.
// A free walks the chain of frames, releasing each, then clears the page map
// entries of the segments that the region covered.
// One command is in progress at a time; cmd.ready is high only while the
// sequencer waits for work.
// The response sits in an output register. A new command is accepted while it
// waits; a finished command whose result cannot yet be loaded waits for
// rsp.ready.
// After reset, a clearing pass writes the frame owner, page map and byte
// memories, during which cmd.ready stays low.
// ----------------------------------------------------------------------------
module paged_frame_allocator_translator
	import pfat_pkg::*;
	#(
	parameter int OFFSET_BITS   = 10,
	parameter int PAGE_BITS     = 5,
	parameter int SEGMENT_BITS  = 5,
	parameter int NUM_FRAMES    = 1024,
	parameter int NUM_PROCESSES = 8,
	parameter int INITIAL_BREAK = 1024
) (
	input logic      clk,
	input logic      arst_n,
	pfat_cmd_if.sink cmd,
	pfat_rsp_if.source rsp
);

	localparam int VA = SEGMENT_BITS + PAGE_BITS + OFFSET_BITS;

	logic                idle;
	logic                done;
	logic                hold;
	logic [STATUS_W-1:0] status;
	logic [VA-1:0]       alloc_address;
	logic [BYTE_W-1:0]   read_byte;
	logic                valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VA-1:0]       addr_q;
	logic [BYTE_W-1:0]   rb_q;

	assign cmd.ready = idle;
	assign hold      = valid_q && !rsp.ready;

	pfat_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.PAGE_BITS(PAGE_BITS),
		.SEGMENT_BITS(SEGMENT_BITS),
		.NUM_FRAMES(NUM_FRAMES),
		.NUM_PROCESSES(NUM_PROCESSES),
		.INITIAL_BREAK(INITIAL_BREAK)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.valid && idle),
		.command(cmd.command),
		.pid(cmd.pid),
		.size_bytes(cmd.size_bytes),
		.vaddr(cmd.vaddr),
		.write_byte(cmd.write_byte),
		.hold(hold),
		.idle(idle),
		.done(done),
		.status(status),
		.alloc_address(alloc_address),
		.read_byte(read_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status;
			addr_q   <= alloc_address;
			rb_q     <= read_byte;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.status        = status_q;
	assign rsp.alloc_address = addr_q;
	assign rsp.read_byte     = rb_q;

endmodule
